/* rtl/deq_pkg.sv */
package deq_pkg;

  localparam int DEPTH = 16;

  localparam int VAL_W  = 32;
  localparam int CMD_W  = 3;
  localparam int STAT_W = 2;

  // Command codes carried in the low bits of s_tdata.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  // Source select for one storage cell.
  typedef logic [2:0] cell_sel_t;

  localparam cell_sel_t CELL_HOLD  = 3'd0;
  localparam cell_sel_t CELL_LEFT  = 3'd1;
  localparam cell_sel_t CELL_RIGHT = 3'd2;
  localparam cell_sel_t CELL_PUSH  = 3'd3;
  localparam cell_sel_t CELL_WRAP  = 3'd4;

  typedef logic signed [VAL_W-1:0] val_t;

endpackage

/* rtl/double_ended_queue.sv */
// Channel  Dir  Beat fields (lowest bit first)
// s_axis   in   tdata: cmd[2:0], push_value[34:3], zero fill to 40 bits
// m_axis   out  tdata: status[1:0], item_value[33:2], zero fill; tlast: last result
//
// Entries sit in a row of cells, front in cell 0; front pushes and front pops shift the row.
// A push or pop is handled in the idle state; a dump enters the dump state and then
// sends the entries in turn, rotating the occupied cells so that the front is back in cell 0 at the end.
// Reset clears the state, the occupancy count and the output valid; cell contents and
// output data are not reset.
// A stalled m_tready holds the output beat and stops input and dump progress.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cmd, push_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // status, item_value
  output logic        m_tlast
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic                         state, state_next;
  logic [CW-1:0]                count, count_next;
  logic [CW-1:0]                remaining, remaining_next;
  logic [CW-1:0]                count_m1;
  deq_pkg::val_t                cells [DEPTH];
  deq_pkg::cell_sel_t           sel [DEPTH];
  logic [deq_pkg::CMD_W-1:0]    cmd;
  deq_pkg::val_t                push_value;
  logic                         accept, out_free, full, empty;
  logic                         emit, emit_last;
  logic [deq_pkg::STAT_W-1:0]   emit_status;
  deq_pkg::val_t                emit_value;

  assign cmd        = s_tdata[deq_pkg::CMD_W-1:0];
  assign push_value = s_tdata[deq_pkg::CMD_W+deq_pkg::VAL_W-1:deq_pkg::CMD_W];
  assign out_free   = !m_tvalid || m_tready;
  assign s_tready   = (state == S_IDLE) && out_free;
  assign accept     = s_tvalid && s_tready;
  assign full       = (count == CW'(DEPTH));
  assign empty      = (count == '0);
  assign count_m1   = count - CW'(1);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    deq_cell u_cell (
      .clk   (clk),
      .sel   (sel[i]),
      .left  ((i == 0) ? push_value : cells[(i == 0) ? 0 : i - 1]),
      .right ((i == DEPTH - 1) ? cells[i] : cells[(i == DEPTH - 1) ? i : i + 1]),
      .wrap  (cells[0]),
      .push  (push_value),
      .q     (cells[i])
    );
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    emit           = 1'b0;
    emit_status    = deq_pkg::ST_OK;
    emit_value     = '0;
    emit_last      = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = deq_pkg::CELL_HOLD;
    end

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            deq_pkg::CMD_PUSH_FRONT: begin
              emit = 1'b1;
              if (full) begin
                emit_status = deq_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  sel[i] = (i == 0) ? deq_pkg::CELL_PUSH : deq_pkg::CELL_LEFT;
                end
                count_next = count + CW'(1);
              end
            end
            deq_pkg::CMD_PUSH_BACK: begin
              emit = 1'b1;
              if (full) begin
                emit_status = deq_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (CW'(i) == count) sel[i] = deq_pkg::CELL_PUSH;
                end
                count_next = count + CW'(1);
              end
            end
            deq_pkg::CMD_POP_FRONT: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = deq_pkg::ST_EMPTY;
              end else begin
                emit_value = cells[0];
                for (int i = 0; i < DEPTH; i++) begin
                  sel[i] = deq_pkg::CELL_RIGHT;
                end
                count_next = count_m1;
              end
            end
            deq_pkg::CMD_POP_BACK: begin
              emit = 1'b1;
              if (empty) begin
                emit_status = deq_pkg::ST_EMPTY;
              end else begin
                emit_value = cells[count_m1[IW-1:0]];
                count_next = count_m1;
              end
            end
            deq_pkg::CMD_DUMP: begin
              if (empty) begin
                emit        = 1'b1;
                emit_status = deq_pkg::ST_EMPTY;
              end else begin
                state_next     = S_DUMP;
                remaining_next = count;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          // The occupied cells rotate by one, so after a full pass they are as before.
          emit       = 1'b1;
          emit_value = cells[0];
          emit_last  = (remaining == CW'(1));
          for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i) < count_m1) begin
              sel[i] = deq_pkg::CELL_RIGHT;
            end else if (CW'(i) == count_m1) begin
              sel[i] = deq_pkg::CELL_WRAP;
            end
          end
          remaining_next = remaining - CW'(1);
          if (emit_last) state_next = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      remaining <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {6'd0, emit_value, emit_status};
      m_tlast <= emit_last;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy beyond depth");

  a_dump_remaining: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> (remaining != '0 && remaining <= count))
    else $error("dump counter out of step with occupancy");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && empty && (cmd == deq_pkg::CMD_POP_FRONT || cmd == deq_pkg::CMD_POP_BACK))
    |=> (m_tvalid && m_tlast && m_tdata[1:0] == deq_pkg::ST_EMPTY && count == '0))
    else $error("pop on empty queue not flagged");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && !full && (cmd == deq_pkg::CMD_PUSH_FRONT || cmd == deq_pkg::CMD_PUSH_BACK))
    |=> (count == $past(count) + CW'(1)))
    else $error("push did not grow the queue");
`endif

endmodule

/* rtl/deq_cell.sv */
module deq_cell (
  input  logic               clk,
  input  deq_pkg::cell_sel_t sel,
  input  deq_pkg::val_t      left,
  input  deq_pkg::val_t      right,
  input  deq_pkg::val_t      wrap,
  input  deq_pkg::val_t      push,
  output deq_pkg::val_t      q
);

  deq_pkg::val_t q_next;

  always_comb begin
    case (sel)
      deq_pkg::CELL_LEFT:  q_next = left;
      deq_pkg::CELL_RIGHT: q_next = right;
      deq_pkg::CELL_PUSH:  q_next = push;
      deq_pkg::CELL_WRAP:  q_next = wrap;
      default:             q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

/* dv/deque_checker.sv */
`timescale 1ns / 1ps

module deque_checker
  import deq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,   // cmd, push_value
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // status, item_value
  input  logic        m_tlast,
  output int          mismatch_count,
  output int          outstanding
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    val_t              value;
    logic              last;
  } deq_result_t;

  deq_result_t results_due[$];

  // Model of the queue as a ring buffer: head is the slot of the front entry.
  val_t        ring_slot [DEPTH];
  int unsigned head;
  int unsigned fill;

  task automatic expect_beat(input logic [STAT_W-1:0] status, input val_t value,
                             input logic last);
    deq_result_t r;
    r.status = status;
    r.value  = value;
    r.last   = last;
    results_due.push_back(r);
  endtask

  task automatic predict_deque_results(input logic [CMD_W-1:0] cmd, input val_t value);
    int unsigned pos;
    int unsigned i;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          expect_beat(ST_FULL, '0, 1'b1);
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            pos  = head;
          end else begin
            pos = (head + fill) % DEPTH;
          end
          ring_slot[pos] = value;
          fill++;
          expect_beat(ST_OK, '0, 1'b1);
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == 0) begin
          expect_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            pos  = head;
            head = (head + 1) % DEPTH;
          end else begin
            pos = (head + fill - 1) % DEPTH;
          end
          fill--;
          expect_beat(ST_OK, ring_slot[pos], 1'b1);
        end
      end
      CMD_DUMP: begin
        if (fill == 0) begin
          expect_beat(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < fill; i++) begin
            expect_beat(ST_OK, ring_slot[(head + i) % DEPTH], i + 1 == fill);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    deq_result_t got;
    deq_result_t want;
    if (rst) begin
      head = 0;
      fill = 0;
      results_due.delete();
      outstanding = 0;
    end else begin
      // The output beat at this edge was caused by an earlier command, so it is
      // checked before the command accepted at the same edge is predicted.
      if (m_tvalid && m_tready) begin
        got.status = m_tdata[1:0];
        got.value  = m_tdata[33:2];
        got.last   = m_tlast;
        if (results_due.size() == 0) begin
          $error("unexpected result beat: status %0d item_value %0d last %0b",
                 got.status, got.value, got.last);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatch_count++;
          end
          if (got.value !== want.value) begin
            $error("item_value: expected %0d, actual %0d", want.value, got.value);
            mismatch_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            mismatch_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_deque_results(s_tdata[2:0], s_tdata[34:3]);
      end
      outstanding = results_due.size();
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import deq_pkg::*;

  localparam int STALL_CYCLES = 200;
  localparam int SETTLE_CYCLES = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  int mismatch_total;
  int beats_owed;
  int src_idle_pct = 25;
  int sink_idle_pct = 69;
  bit long_stall = 1'b0;

  double_ended_queue DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  deque_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_total),
    .outstanding    (beats_owed)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Returns at the edge where the beat is taken; the caller then either offers
  // the next beat or lowers tvalid, never both in one step.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input val_t value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, value, cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
  endtask

  function automatic val_t pick_value();
    case ($urandom_range(15))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Runs alternate between a filling and a draining bias so that the queue
  // spends time both full and empty.
  task automatic send_mixed(input int count);
    int              run_left;
    bit              filling;
    int              roll;
    int              push_cut;
    int              pop_cut;
    logic [CMD_W-1:0] cmd;
    run_left = 0;
    filling  = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        filling  = !filling;
        run_left = $urandom_range(50, 25);
      end
      run_left--;
      push_cut = filling ? 60 : 25;
      pop_cut  = filling ? 85 : 80;
      roll = $urandom_range(99);
      if (roll < push_cut) begin
        cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else if (roll < pop_cut) begin
        cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end else if (roll < 95) begin
        cmd = CMD_DUMP;
      end else begin
        cmd = CMD_W'($urandom_range(2**CMD_W - 1, CMD_DUMP + 1));
      end
      send_command(cmd, pick_value());
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (long_stall) begin
        m_tready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        long_stall = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Pops and dump on an empty queue; the value field must be ignored.
    send_command(CMD_POP_FRONT, 32'sh7fff_ffff);
    send_command(CMD_POP_BACK, 32'sh8000_0000);
    send_command(CMD_DUMP, '1);
    for (int i = 0; i < DEPTH; i++) begin
      send_command(i % 2 ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                   i == 0 ? 32'sh7fff_ffff : i == 1 ? 32'sh8000_0000 :
                   i == 2 ? 32'sh0 : i == 3 ? -32'sd1 : val_t'($urandom));
    end
    // Both pushes meet a full queue and are dropped.
    send_command(CMD_PUSH_FRONT, $urandom);
    send_command(CMD_PUSH_BACK, $urandom);
    send_command(CMD_DUMP, '0);
    send_command(CMD_POP_FRONT, '0);
    send_command(CMD_POP_BACK, '0);
    for (int c = CMD_DUMP + 1; c < 2**CMD_W; c++) begin
      send_command(c[CMD_W-1:0], $urandom);
    end

    send_mixed(110);
    wait_for_drain();

    src_idle_pct  = 69;
    sink_idle_pct = 25;
    send_mixed(110);
    wait_for_drain();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    long_stall    = 1'b1;
    send_mixed(100);
    wait_for_drain();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
dv/deque_checker.sv
dv/testbench.sv
